[hdl/afc_pkg.sv]
// ============================================================================
// afc_pkg: shared types, codes and colour arithmetic
// Holds the field widths, request codes, register indexes and the mapping
// from a normalised Q0.16 height to an RGB triple.
// ============================================================================
package afc_pkg;

  // Field widths of the channels and of the configuration port.
  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 6;
  localparam int HEIGHT_W  = 16;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Request codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_LOAD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEW_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // Q0.16 fixed point: sixteen fraction bits, one needs seventeen bits.
  localparam int          Q_BITS = 16;
  localparam logic [16:0] Q_ONE  = 17'h10000;
  localparam logic [16:0] Q_HALF = 17'h08000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Control strobes from the sequencer to the cell store.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } afc_mem_ctl_t;

  // floor(255 * x / 65536) for x in [0, 65536].
  function automatic logic [CHAN_W-1:0] scale255(input logic [16:0] x);
    logic [24:0] prod;
    prod = {x, 8'b0} - {8'b0, x};
    return prod[23:16];
  endfunction

  // Blue to green over the lower half, green to red over the upper half.
  function automatic rgb_t colour_map(input logic [16:0] n);
    rgb_t        c;
    logic [16:0] f;
    logic [16:0] fc;
    if (n <= Q_HALF) begin
      f       = {n[15:0], 1'b0};
      fc      = Q_ONE - f;
      c.red   = '0;
      c.green = scale255(f);
      c.blue  = scale255(fc);
    end else begin
      f       = 17'({n, 1'b0} - {1'b0, Q_ONE});
      fc      = Q_ONE - f;
      c.red   = scale255(f);
      c.green = scale255(fc);
      c.blue  = '0;
    end
    return c;
  endfunction

endpackage

[hdl/afc_in_if.sv]
// ============================================================================
// afc_in_if: request channel
// Valid/ready channel carrying one request beat: function, cell and sample.
// ============================================================================
interface afc_in_if import afc_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [COORD_W-1:0]         row;
  logic [COORD_W-1:0]         col;
  logic signed [HEIGHT_W-1:0] height;

  modport source (output valid, output func, output row, output col, output height,
                  input ready);
  modport sink   (input valid, input func, input row, input col, input height,
                  output ready);

endinterface

[hdl/afc_out_if.sv]
// ============================================================================
// afc_out_if: colour result channel
// Valid/ready channel carrying one result beat: the cell's colour and flag.
// ============================================================================
interface afc_out_if import afc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              cell_loaded;

  modport source (output valid, output red, output green, output blue,
                  output cell_loaded, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input cell_loaded, output ready);

endinterface

[hdl/afc_cell_store.sv]
// ============================================================================
// afc_cell_store: height grid memory with loaded flags
// One write and one registered read port. Each word holds the loaded flag
// over the sample. A clearing sweep zeroes the flags one word per cycle.
// ============================================================================
module afc_cell_store import afc_pkg::*; #(
  parameter int CELL_COUNT = 4096,
  parameter int AW         = 12,
  parameter int DW         = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  afc_mem_ctl_t  ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  output logic          clearing
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);

  logic [DW-1:0] cell_mem [CELL_COUNT];
  logic [DW-1:0] rd_data_r;
  logic          clearing_r;
  logic [AW-1:0] sweep_r;

  // Sweep control: starts at reset and on every new frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      sweep_r    <= '0;
    end else if (ctl.clear) begin
      clearing_r <= 1'b1;
      sweep_r    <= '0;
    end else if (clearing_r) begin
      if (sweep_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // Memory array: the sweep has the write port while it runs.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      cell_mem[sweep_r] <= '0;
    end else if (ctl.wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= cell_mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

[hdl/afc_serial_div.sv]
// ============================================================================
// afc_serial_div: bit-serial fraction divider
// Computes floor(num * 2^16 / den) for 0 < num < den, one quotient bit per
// cycle by restoring division, shifting the quotient in from the right.
// ============================================================================
module afc_serial_div import afc_pkg::*; #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  output logic              done,
  output logic [Q_BITS-1:0] quot
);

  localparam int                 CW       = $clog2(Q_BITS);
  localparam logic [CW-1:0]      LAST_BIT = CW'(Q_BITS - 1);

  logic [W-1:0]      rem_r;
  logic [W-1:0]      den_r;
  logic [Q_BITS-1:0] quot_r;
  logic [CW-1:0]     bit_r;
  logic              busy_r;
  logic              done_r;
  logic [W:0]        rem2;
  logic              fits;

  // Remainder stays below the divisor, so its double fits in W+1 bits.
  assign rem2 = {rem_r, 1'b0};
  assign fits = rem2 >= {1'b0, den_r};

  // Control: step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
      end else if (busy_r) begin
        bit_r <= bit_r + 1'b1;
        if (bit_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one trial subtraction per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= fits ? W'(rem2 - {1'b0, den_r}) : W'(rem2);
      quot_r <= {quot_r[Q_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[hdl/autoscaled_height_false_color.sv]
// A load is written at the accepting edge and the block is ready for the next
// request in the following cycle. A read passes through the read, prep,
// divide and colour states before its result sits in the output register.
// The memory read is issued at the accepting edge. The read state forms the
// offsets, the prep state classifies them, the bit-serial divider produces
// the 16-bit fraction, and the colour step maps it. A read whose fraction is
// clamped, or one in an empty or flat frame, skips the divider. The next
// request is taken in the cycle after the result is registered. A result beat
// that the sink leaves waiting holds a following read in its colour step.
// A new-frame request, and likewise reset, starts a sweep that clears the
// loaded flags of all GRID_ROWS*GRID_COLS cells (4096 by default), during which
// no request is accepted; configuration writes are taken at any time.
// ============================================================================
// autoscaled_height_false_color: min/max normalised false colour map
// Stores a grid of signed height samples, tracks the frame's extremes and
// returns the blue-green-red colour of a cell scaled between them.
// ============================================================================
module autoscaled_height_false_color import afc_pkg::*; #(
  parameter int GRID_ROWS   = 64,
  parameter int GRID_COLS   = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  afc_in_if.sink               in_bus,
  afc_out_if.source            out_bus,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
  localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int HB         = HEIGHT_BITS;
  localparam int DW         = HB + 1;
  localparam int LIM_W      = 11;

  localparam logic [AW-1:0]    COLS_A   = AW'(GRID_COLS);
  localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(GRID_ROWS);
  localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(GRID_COLS);
  localparam logic [HB-1:0]    SMAX     = {1'b0, {(HB-1){1'b1}}};
  localparam logic [HB-1:0]    SMIN     = {1'b1, {(HB-1){1'b0}}};

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_COLOUR = 3'd5;

  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  logic [CFG_W-1:0]     rows_r;
  logic [CFG_W-1:0]     cols_r;
  logic signed [HB-1:0] lo_r;
  logic signed [HB-1:0] hi_r;
  logic                 ok_r;
  logic                 loaded_r;
  logic signed [HB:0]   t_r;
  logic signed [HB:0]   d_r;
  logic [16:0]          n_r;
  logic                 out_valid_r;
  rgb_t                 out_rgb_r;
  logic                 out_loaded_r;

  logic                 in_fire;
  logic                 cell_ok;
  logic [AW-1:0]        cell_idx;
  logic signed [HB-1:0] sample;
  afc_mem_ctl_t         mem_ctl;
  logic [DW-1:0]        rd_data;
  logic                 clearing;
  logic                 rd_loaded;
  logic signed [HB-1:0] h_sel;
  logic                 div_start;
  logic                 div_done;
  logic [Q_BITS-1:0]    div_quot;
  logic                 out_load;

  // Request decode: cell range check and grid address.
  assign in_fire  = in_bus.valid & in_bus.ready;
  assign cell_ok  = ({1'b0, in_bus.row} < rows_r) && (LIM_W'(in_bus.row) < ROWS_LIM) &&
                    ({1'b0, in_bus.col} < cols_r) && (LIM_W'(in_bus.col) < COLS_LIM);
  assign cell_idx = AW'(in_bus.row) * COLS_A + AW'(in_bus.col);
  assign sample   = $signed(HB'($unsigned(in_bus.height)));

  always_comb begin
    mem_ctl = '0;
    if (in_fire) begin
      unique case (in_bus.func)
        FUNC_LOAD:      mem_ctl.wr_en = cell_ok;
        FUNC_READ:      mem_ctl.rd_en = 1'b1;
        FUNC_NEW_FRAME: mem_ctl.clear = 1'b1;
        default:        mem_ctl = '0;
      endcase
    end
  end

  afc_cell_store #(
    .CELL_COUNT (CELL_COUNT),
    .AW         (AW),
    .DW         (DW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .wr_addr  (cell_idx),
    .wr_data  ({1'b1, sample}),
    .rd_addr  (cell_idx),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(64);
      cols_r <= CFG_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROWS: rows_r <= cfg_wr_data;
        CFG_COLS: cols_r <= cfg_wr_data;
        default:  rows_r <= rows_r;
      endcase
    end
  end

  // Frame extremes, updated by every accepted in-range load.
  always_ff @(posedge clk) begin
    if (!rst_n || mem_ctl.clear) begin
      lo_r <= $signed(SMAX);
      hi_r <= $signed(SMIN);
    end else if (mem_ctl.wr_en) begin
      if (sample > hi_r) begin
        hi_r <= sample;
      end
      if (sample < lo_r) begin
        lo_r <= sample;
      end
    end
  end

  // Sequencer for reads and the clearing sweep.
  assign rd_loaded = ok_r & rd_data[HB];
  assign h_sel     = rd_loaded ? $signed(rd_data[HB-1:0]) : '0;
  assign div_start = (state_r == S_PREP) && (d_r > 0) && (t_r > 0) && (t_r < d_r);
  assign out_load  = (state_r == S_COLOUR) && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (!clearing) state_nxt = S_IDLE;
      S_IDLE: begin
        if (mem_ctl.clear) begin
          state_nxt = S_CLEAR;
        end else if (mem_ctl.rd_en) begin
          state_nxt = S_READ;
        end
      end
      S_READ:   state_nxt = S_PREP;
      S_PREP:   state_nxt = div_start ? S_DIV : S_COLOUR;
      S_DIV:    if (div_done) state_nxt = S_COLOUR;
      S_COLOUR: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Read datapath: offsets from the minimum, then the Q0.16 fraction.
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      ok_r <= cell_ok;
    end
    if (state_r == S_READ) begin
      loaded_r <= rd_loaded;
      t_r      <= {h_sel[HB-1], h_sel} - {lo_r[HB-1], lo_r};
      d_r      <= {hi_r[HB-1], hi_r} - {lo_r[HB-1], lo_r};
    end
    if (state_r == S_PREP) begin
      if (d_r > 0 && t_r >= d_r) begin
        n_r <= Q_ONE;
      end else begin
        n_r <= '0;
      end
    end else if (state_r == S_DIV && div_done) begin
      n_r <= {1'b0, div_quot};
    end
  end

  afc_serial_div #(
    .W (HB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (t_r[HB-1:0]),
    .den   (d_r[HB-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Output register: holds a finished beat while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb_r    <= colour_map(n_r);
      out_loaded_r <= loaded_r;
    end
  end

  assign in_bus.ready        = (state_r == S_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.red         = out_rgb_r.red;
  assign out_bus.green       = out_rgb_r.green;
  assign out_bus.blue        = out_rgb_r.blue;
  assign out_bus.cell_loaded = out_loaded_r;

endmodule

[hdl/afc_checker.sv]
// ============================================================================
// afc_checker: port-level assertions
// Watches the request and result channels of the false colour block.
// ============================================================================
module afc_checker import afc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [FUNC_W-1:0] in_func,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue,
  input logic              out_loaded
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_loaded))
    else $error("result payload changed while stalled");

  // The colour ramp never mixes red with blue.
  a_no_magenta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == '0) || (out_blue == '0))
    else $error("result carries both red and blue");

  // A new frame starts the flag sweep, so requests are held off.
  a_new_frame_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_NEW_FRAME) |=> !in_ready)
    else $error("request taken during the clearing sweep");

  // The sweep after reset holds off requests as well.
  a_reset_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken straight after reset");

endmodule

bind autoscaled_height_false_color afc_checker u_afc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_func    (in_bus.func),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_red    (out_bus.red),
  .out_green  (out_bus.green),
  .out_blue   (out_bus.blue),
  .out_loaded (out_bus.cell_loaded)
);
